// ----- hdl/tdnp_pkg.sv -----
// constants, mode codes and the delta sizing helper for the timestamp delta packer
// no dependencies
package tdnp_pkg;

	localparam int unsigned SecW    = 32;
	localparam int unsigned UsW     = 20;
	localparam int unsigned DeltaW  = 24;
	localparam int unsigned BufW    = 56;
	localparam int unsigned CntW    = 3;

	localparam logic [DeltaW-1:0] USEC_PER_SEC = 24'd1000000;
	localparam logic [DeltaW-1:0] SIZE1_LIMIT  = 24'd255;
	localparam logic [DeltaW-1:0] SIZE2_LIMIT  = 24'd65535;
	localparam logic [SecW-1:0]   DAY_LIMIT    = 32'd86400;
	localparam logic [3:0]        FLUSH_PAD    = 4'h5;

	typedef enum logic [1:0] {
		MODE_LOAD   = 2'd0,
		MODE_ENCODE = 2'd1,
		MODE_FLUSH  = 2'd2
	} mode_t;

	// byte count of a nonzero delta
	function automatic logic [1:0] delta_size(input logic [DeltaW-1:0] d);
		logic [1:0] sz;
		if (d < SIZE1_LIMIT) begin
			sz = 2'd1;
		end else if (d < SIZE2_LIMIT) begin
			sz = 2'd2;
		end else begin
			sz = 2'd3;
		end
		return sz;
	endfunction

endpackage

// ----- hdl/timestamp_delta_nibble_packer.sv -----
// timestamp delta nibble packer: input register, single-pass code build, byte serializer
// depends on tdnp_pkg
// path: input register, code build, output shift register, which offers the first byte
// throughput: one output byte per cycle while out_stall is low; an item gives 0 to 7
// bytes, held in the output shift register; items with no bytes do not wait for it
// a new item is built while the last byte of the previous one is being taken
// reset (arst_n low, asynchronous): no item held, reference timestamp zero, no nibble held
module timestamp_delta_nibble_packer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic [tdnp_pkg::SecW-1:0]    seconds,
	input  logic [tdnp_pkg::UsW-1:0]     micros,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [7:0]                   out_byte,
	output logic                         last,
	output logic                         gap_error
);
	import tdnp_pkg::*;

	// input register
	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [SecW-1:0]      sec_s1;
	logic [UsW-1:0]       us_s1;

	// coder state
	logic [SecW-1:0]      prev_sec_q;
	logic [UsW-1:0]       prev_us_q;
	logic                 pending_q;
	logic [3:0]           held_q;

	// output shift register
	logic [BufW-1:0]      buf_s2;
	logic [CntW-1:0]      cnt_s2;
	logic                 err_s2;

	// combinational code build
	logic [SecW:0]        sdiff;
	logic                 gap;
	logic [16:0]          sd;
	logic [16:0]          sd_b;
	logic                 wrap;
	logic [DeltaW-1:0]    ud;
	logic [1:0]           ssz;
	logic [1:0]           usz;
	logic [DeltaW-1:0]    sd_left;
	logic [DeltaW-1:0]    ud_left;
	logic [51:0]          code;
	logic [BufW-1:0]      stream;
	logic [3:0]           nib_n;
	logic [BufW-1:0]      tail_shift;

	logic                 in_xfer;
	logic                 out_xfer;
	logic                 s2_free;
	logic                 go;
	logic                 load_s2;
	logic [BufW-1:0]      buf_new;
	logic [CntW-1:0]      cnt_new;
	logic                 err_new;
	logic                 upd_ref;
	logic                 upd_nib;
	logic                 pending_new;
	logic [3:0]           held_new;

	always_comb begin
		sdiff = {1'b0, sec_s1} - {1'b0, prev_sec_q};
		gap   = sdiff[SecW] || (sdiff[SecW-1:0] >= DAY_LIMIT);
		sd    = sdiff[16:0];
		wrap  = us_s1 < prev_us_q;
		if (wrap) begin
			ud = USEC_PER_SEC - DeltaW'(prev_us_q) + DeltaW'(us_s1);
		end else begin
			ud = DeltaW'(us_s1) - DeltaW'(prev_us_q);
		end
		sd_b = (wrap && sd != '0) ? sd - 17'd1 : sd;
		ssz  = (sd_b == '0) ? 2'd0 : delta_size(DeltaW'(sd));
		usz  = (us_s1 == prev_us_q) ? 2'd0 : delta_size(ud);
		// left-align each delta on its byte count, zero when the size is zero
		sd_left = DeltaW'(sd_b) << {2'd3 - ssz, 3'b000};
		ud_left = ud << {2'd3 - usz, 3'b000};
		code = {ssz, usz, sd_left, 24'd0} | ({4'd0, ud_left, 24'd0} >> {ssz, 3'b000});
		stream = pending_q ? {held_q, code} : {code, 4'd0};
		nib_n  = 4'(pending_q) + 4'd1 + {3'(ssz) + 3'(usz), 1'b0};
		tail_shift = stream << {nib_n - 4'd1, 2'b00};
	end

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign s2_free  = (cnt_s2 == '0) || (cnt_s2 == CntW'(1) && !out_stall);

	// what the held item does
	always_comb begin
		buf_new     = '0;
		cnt_new     = '0;
		err_new     = 1'b0;
		upd_ref     = 1'b0;
		upd_nib     = 1'b0;
		pending_new = pending_q;
		held_new    = held_q;
		unique case (mode_t'(mode_s1))
			MODE_LOAD: begin
				upd_ref = 1'b1;
			end
			MODE_ENCODE: begin
				if (gap) begin
					cnt_new = CntW'(1);
					err_new = 1'b1;
				end else begin
					upd_ref     = 1'b1;
					upd_nib     = 1'b1;
					buf_new     = stream;
					cnt_new     = nib_n[3:1];
					pending_new = nib_n[0];
					held_new    = nib_n[0] ? tail_shift[BufW-1 -: 4] : held_q;
				end
			end
			MODE_FLUSH: begin
				if (pending_q) begin
					buf_new     = {held_q, FLUSH_PAD, 48'd0};
					cnt_new     = CntW'(1);
					upd_nib     = 1'b1;
					pending_new = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign go       = valid_s1 && ((cnt_new == '0) || s2_free);
	assign load_s2  = go && (cnt_new != '0);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_s1 <= mode;
			sec_s1  <= seconds;
			us_s1   <= micros;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sec_q <= '0;
			prev_us_q  <= '0;
			pending_q  <= 1'b0;
			held_q     <= '0;
		end else if (go) begin
			if (upd_ref) begin
				prev_sec_q <= sec_s1;
				prev_us_q  <= us_s1;
			end
			if (upd_nib) begin
				pending_q <= pending_new;
				held_q    <= held_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load_s2) begin
			cnt_s2 <= cnt_new;
		end else if (out_xfer) begin
			cnt_s2 <= cnt_s2 - CntW'(1);
		end
	end

	// shift one byte out per transfer
	always_ff @(posedge clk) begin
		if (load_s2) begin
			buf_s2 <= buf_new;
			err_s2 <= err_new;
		end else if (out_xfer) begin
			buf_s2 <= {buf_s2[BufW-9:0], 8'd0};
		end
	end

	assign out_valid = (cnt_s2 != '0);
	assign out_byte  = buf_s2[BufW-1 -: 8];
	assign last      = (cnt_s2 == CntW'(1));
	assign gap_error = err_s2;

`ifndef SYNTHESIS
	a_load_only_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |-> (cnt_s2 == '0) || (cnt_s2 == CntW'(1) && !out_stall))
		else $error("output register reloaded with bytes still pending");

	a_gap_single_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gap_error) |-> (last && out_byte == 8'd0))
		else $error("gap error result is not a single zero byte");

	a_gap_keeps_reference: assert property (@(posedge clk) disable iff (!arst_n)
		(go && mode_s1 == MODE_ENCODE && gap) |=> ($stable(prev_sec_q) && $stable(prev_us_q)
		&& $stable(pending_q)))
		else $error("dropped timestamp changed coder state");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && cnt_new != '0 && out_valid))
		else $error("input stalled without a blocked item");
`endif

endmodule

// ----- verif/tb_timestamp_delta_nibble_packer.sv -----
// testbench for the timestamp delta nibble packer: directed and random timestamps
// are checked byte by byte against a predictor kept in a scoreboard class
// depends on tdnp_pkg and timestamp_delta_nibble_packer
`timescale 1ns / 1ps

module tb_timestamp_delta_nibble_packer;
	import tdnp_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned USEC_MAX = 999999;

	class code_stream_board;
		typedef struct packed {
			logic [7:0] data;
			logic       last;
			logic       err;
		} stream_byte_t;

		stream_byte_t expected_bytes[$];
		logic [SecW-1:0] ref_sec;
		logic [UsW-1:0]  ref_us;
		logic            nib_held;
		logic [3:0]      held_val;
		int              errors;

		function new();
			ref_sec  = '0;
			ref_us   = '0;
			nib_held = 1'b0;
			held_val = 4'h0;
			errors   = 0;
		endfunction

		function logic [1:0] byte_count(logic [31:0] d);
			if (d < 32'd255) begin
				return 2'd1;
			end
			if (d < 32'd65535) begin
				return 2'd2;
			end
			return 2'd3;
		endfunction

		function void push_byte(logic [7:0] data, logic last, logic err);
			stream_byte_t e;
			e.data = data;
			e.last = last;
			e.err  = err;
			expected_bytes.push_back(e);
		endfunction

		// work out the bytes one accepted transfer causes
		function void take_timestamp(logic [1:0] m, logic [SecW-1:0] s, logic [UsW-1:0] u);
			logic [31:0] sd;
			logic [23:0] ud;
			logic [1:0]  ssz;
			logic [1:0]  usz;
			logic [3:0]  nib[14];
			logic [7:0]  bv;
			int          n;
			int          cnt;
			int          b;
			if (m == MODE_LOAD) begin
				ref_sec = s;
				ref_us  = u;
				return;
			end
			if (m == MODE_FLUSH) begin
				if (nib_held) begin
					push_byte({held_val, FLUSH_PAD}, 1'b1, 1'b0);
					nib_held = 1'b0;
				end
				return;
			end
			if (m != MODE_ENCODE) begin
				return;
			end
			if (s < ref_sec || (s - ref_sec) >= DAY_LIMIT) begin
				push_byte(8'h00, 1'b1, 1'b1);
				return;
			end
			sd  = s - ref_sec;
			ssz = (sd == 0) ? 2'd0 : byte_count(sd);
			if (u >= ref_us) begin
				ud = {4'h0, u} - {4'h0, ref_us};
			end else begin
				// microsecond wrap borrows a second, size already taken
				ud = USEC_PER_SEC - {4'h0, ref_us} + {4'h0, u};
				if (sd != 0) begin
					sd = sd - 1;
				end
			end
			usz = (u == ref_us) ? 2'd0 : byte_count({8'h00, ud});
			if (sd == 0) begin
				ssz = 2'd0;
			end
			n = 0;
			if (nib_held) begin
				nib[n] = held_val;
				n = n + 1;
			end
			nib[n] = {ssz, usz};
			n = n + 1;
			for (b = ssz; b > 0; b--) begin
				bv = 8'(sd >> (8 * (b - 1)));
				nib[n]     = bv[7:4];
				nib[n + 1] = bv[3:0];
				n = n + 2;
			end
			for (b = usz; b > 0; b--) begin
				bv = 8'(ud >> (8 * (b - 1)));
				nib[n]     = bv[7:4];
				nib[n + 1] = bv[3:0];
				n = n + 2;
			end
			if (n % 2 == 1) begin
				held_val = nib[n - 1];
				nib_held = 1'b1;
				n = n - 1;
			end else begin
				nib_held = 1'b0;
			end
			cnt = n / 2;
			for (int k = 0; k < cnt; k++) begin
				push_byte({nib[2 * k], nib[2 * k + 1]}, k == cnt - 1, 1'b0);
			end
			ref_sec = s;
			ref_us  = u;
		endfunction

		function void check_byte(logic [7:0] data, logic last, logic err);
			stream_byte_t e;
			if (expected_bytes.size() == 0) begin
				$display("%0t unexpected byte: got %02h last %0b gap_error %0b",
					$time, data, last, err);
				errors++;
				return;
			end
			e = expected_bytes.pop_front();
			if (data !== e.data || last !== e.last || err !== e.err) begin
				$display({"%0t mismatch: expected %02h last %0b gap_error %0b,",
					" got %02h last %0b gap_error %0b"},
					$time, e.data, e.last, e.err, data, last, err);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        mode = MODE_LOAD;
	logic [SecW-1:0]   seconds = '0;
	logic [UsW-1:0]    micros = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        out_byte;
	logic              last;
	logic              gap_error;

	code_stream_board sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	timestamp_delta_nibble_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.seconds   (seconds),
		.micros    (micros),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last),
		.gap_error (gap_error)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_byte(out_byte, last, gap_error);
		end
	end

	task automatic send(input logic [1:0] m, input logic [SecW-1:0] s, input logic [UsW-1:0] u);
		int idle;
		idle = 0;
		while ($urandom_range(99) < send_idle_pct) begin
			idle++;
		end
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		seconds  <= s;
		micros   <= u;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.take_timestamp(m, s, u);
	endtask

	// stop offering and wait for every expected byte
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (sb.expected_bytes.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [UsW-1:0] rand_us();
		if ($urandom_range(7) == 0) begin
			return UsW'($urandom_range(USEC_MAX, 20'hFFFFF));
		end
		return UsW'($urandom_range(0, USEC_MAX));
	endfunction

	task automatic random_item(output bit counted);
		int          pick;
		int          cat;
		logic [31:0] delta;
		logic [UsW-1:0] u;
		counted = 1'b1;
		pick = $urandom_range(99);
		if (pick < 10) begin
			send(MODE_LOAD, $urandom, rand_us());
		end else if (pick < 18) begin
			send(MODE_FLUSH, $urandom, UsW'($urandom));
		end else if (pick < 21) begin
			send(MODE_UNUSED, $urandom, UsW'($urandom));
			counted = 1'b0;
		end else if (pick < 26) begin
			// seconds going backwards
			send(MODE_ENCODE, sb.ref_sec - $urandom_range(1, 100000), rand_us());
		end else begin
			cat = $urandom_range(9);
			case (cat)
				0: delta = 0;
				1, 2, 3, 4: delta = $urandom_range(1, 254);
				5: begin
					case ($urandom_range(3))
						0: delta = 254;
						1: delta = 255;
						2: delta = 65534;
						default: delta = 65535;
					endcase
				end
				6, 7: delta = $urandom_range(255, 65534);
				8: delta = $urandom_range(65535, 86399);
				default: delta = ($urandom_range(1) == 0) ? $urandom_range(86400, 87000) : $urandom;
			endcase
			case ($urandom_range(3))
				0: u = sb.ref_us;
				1: u = sb.ref_us + UsW'($urandom_range(0, 300));
				default: u = rand_us();
			endcase
			send(MODE_ENCODE, sb.ref_sec + delta, u);
		end
	endtask

	initial begin
		bit counted;
		int items;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, no idling
		send(MODE_FLUSH, 32'd0, 20'd0);
		send(MODE_ENCODE, 32'd0, 20'd0);
		send(MODE_FLUSH, 32'd0, 20'd0);
		send(MODE_ENCODE, 32'd1, 20'd1);
		send(MODE_ENCODE, 32'd255, 20'd255);
		send(MODE_ENCODE, 32'd510, 20'd510);
		send(MODE_ENCODE, 32'd66044, 20'd66044);
		send(MODE_ENCODE, 32'd131579, 20'd131579);
		send(MODE_ENCODE, 32'd217978, 20'd999999);
		send(MODE_ENCODE, 32'd217979, 20'd0);
		send(MODE_ENCODE, 32'd217979, 20'd999998);
		send(MODE_ENCODE, 32'd304378, 20'd999998);
		send(MODE_ENCODE, 32'd304377, 20'd999998);
		send(MODE_ENCODE, 32'd304380, 20'hFFFFF);
		send(MODE_ENCODE, 32'd304390, 20'd0);
		send(MODE_LOAD, 32'hFFFFFFFF, 20'd0);
		send(MODE_ENCODE, 32'hFFFFFFFF, 20'd0);
		send(MODE_UNUSED, 32'hFFFFFFFF, 20'hFFFFF);
		send(MODE_LOAD, 32'hFFFF0000, 20'd500000);
		send(MODE_ENCODE, 32'hFFFF0000 + 32'd86399, 20'd499999);
		send(MODE_ENCODE, 32'hFFFFFFFF, 20'd0);
		send(MODE_FLUSH, 32'hFFFFFFFF, 20'hFFFFF);
		send(MODE_FLUSH, 32'd0, 20'd0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			if (ph == 2) begin
				// long hold-off while items keep coming, so the input backs up
				hold_left = 80;
			end
			items = 0;
			while (items < 26) begin
				random_item(counted);
				if (counted) begin
					items++;
				end
			end
			drain();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		send(MODE_FLUSH, 32'd0, 20'd0);
		drain();
		if (sb.expected_bytes.size() != 0) begin
			$display("%0t %0d expected bytes never arrived", $time, sb.expected_bytes.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
